[src/ring_task_picker_assert.svh]
// Assertion macros shared by the task picker RTL.
`ifndef RING_TASK_PICKER_ASSERT_SVH
`define RING_TASK_PICKER_ASSERT_SVH

// A condition that holds at every clock edge out of reset.
`define RTP_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("ring_task_picker: invariant violated");

// A condition that implies another in the same cycle.
`define RTP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ring_task_picker: implication violated");

// A condition that implies another in the following cycle.
`define RTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ring_task_picker: sequence violated");

`endif

[src/rtp_pkg.sv]
`default_nettype none

package rtp_pkg;

    // Slot geometry.
    localparam int SLOT_W    = 4;
    localparam int MAX_TASKS = 1 << SLOT_W;
    localparam int STEP_W    = $clog2(MAX_TASKS + 1);

    // Fixed slots.
    localparam logic [SLOT_W-1:0] HK_SLOT   = SLOT_W'(0);
    localparam logic [SLOT_W-1:0] IDLE_SLOT = SLOT_W'(1);

    // Configuration reset values.
    localparam logic [7:0] SLICE_TICKS_RST = 8'd10;
    localparam logic [7:0] HK_INTERVAL_RST = 8'd10;
    localparam logic [7:0] COUNT_MAX       = 8'hFF;

    // Configuration register indexes.
    typedef enum logic
    {
        CFG_SLICE_TICKS = 1'b0,
        CFG_HK_INTERVAL = 1'b1
    } cfg_idx_t;

    // Operation codes.
    typedef enum logic [2:0]
    {
        OP_TICK    = 3'd0,
        OP_YIELD   = 3'd1,
        OP_PREEMPT = 3'd2,
        OP_ADD     = 3'd3,
        OP_SET     = 3'd4,
        OP_REMOVE  = 3'd5
    } op_t;

    // Task run states.
    typedef enum logic [2:0]
    {
        TS_READY   = 3'd0,
        TS_RUNNING = 3'd1,
        TS_BLOCKED = 3'd2,
        TS_ZOMBIE  = 3'd3,
        TS_STOPPED = 3'd4
    } task_state_t;

    // Result status codes.
    typedef enum logic [1:0]
    {
        RES_DONE    = 2'd0,
        RES_NOCHG   = 2'd1,
        RES_REFUSED = 2'd2
    } res_t;

    // One entry of the link memory: user flag and ring successor.
    typedef struct packed
    {
        logic              user;
        logic [SLOT_W-1:0] link;
    } link_ent_t;

    // Sequencer states.
    typedef enum logic [12:0]
    {
        S_IDLE      = 13'b0000000000001,
        S_SEL_START = 13'b0000000000010,
        S_SEL_WALK  = 13'b0000000000100,
        S_DECIDE    = 13'b0000000001000,
        S_SW_PREV   = 13'b0000000010000,
        S_SW_NEXT   = 13'b0000000100000,
        S_ADD_CUR   = 13'b0000001000000,
        S_ADD_LINK  = 13'b0000010000000,
        S_SET_WR    = 13'b0000100000000,
        S_RM_WALK   = 13'b0001000000000,
        S_RM_SLOT   = 13'b0010000000000,
        S_RM_CLR    = 13'b0100000000000,
        S_RESULT    = 13'b1000000000000
    } fsm_t;

    // A task may be picked when it is ready or already running.
    function automatic logic runnable(input task_state_t s);
        return (s == TS_READY) || (s == TS_RUNNING);
    endfunction

endpackage

`default_nettype wire

[src/ring_task_picker.sv]
`default_nettype none

// Round-robin task picker over a ring of sixteen task slots. Slot 0 is the
// housekeeping task and runs after reset; slot 1 is the idle task. One input
// word is one operation (tick, yield, preemption check, add, set state,
// remove) and gives exactly one result word. Run states and ring links live
// in two synchronous memories, each with one write port and one read port; a
// sequencer reads one ring link per cycle as a yield, a preemption check or a
// remove walks the ring. A result waits in S_RESULT while the output
// register is still full. One word is worked on at a time; a finished result
// waits in the output register while the next word is taken. Configuration
// writes are always ready.
module ring_task_picker
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // Operation channel.
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [2:0]                opcode,
    input  wire logic [rtp_pkg::SLOT_W-1:0] task_slot,
    input  wire logic                      user_task,
    input  wire logic [2:0]                new_state,
    // Result channel.
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic                           switched,
    output logic [rtp_pkg::SLOT_W-1:0]     prev_task,
    output logic [rtp_pkg::SLOT_W-1:0]     running_task,
    output logic [1:0]                     status,
    // Configuration write channel.
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic                      cfg_index,
    input  wire logic [7:0]                cfg_data
);

    import rtp_pkg::*;

    // Memories and their read side.
    task_state_t             state_mem [MAX_TASKS];
    link_ent_t               link_mem  [MAX_TASKS];
    task_state_t             st_rdata_reg;
    link_ent_t               ln_rdata_reg;
    logic                    st_seen_rd_reg;
    logic                    ln_seen_rd_reg;
    logic [SLOT_W-1:0]       rd_addr_reg;
    logic [MAX_TASKS-1:0]    st_seen_reg;
    logic [MAX_TASKS-1:0]    ln_seen_reg;

    // Memory access controls.
    logic [SLOT_W-1:0]       rd_addr;
    logic                    st_we;
    logic [SLOT_W-1:0]       st_waddr;
    task_state_t             st_wdata;
    logic                    ln_we;
    logic [SLOT_W-1:0]       ln_waddr;
    link_ent_t               ln_wdata;
    task_state_t             rd_state;
    link_ent_t               rd_ent;

    // Control and working registers.
    fsm_t                    fsm_reg, fsm_next;
    logic [SLOT_W-1:0]       current_reg, current_next;
    logic [7:0]              slice_cnt_reg, slice_cnt_next;
    logic [7:0]              yield_cnt_reg, yield_cnt_next;
    logic [7:0]              slice_ticks_reg, slice_ticks_next;
    logic [7:0]              hk_interval_reg, hk_interval_next;
    logic [MAX_TASKS-1:0]    valid_reg, valid_next;
    op_t                     op_reg, op_next;
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic                    user_reg, user_next;
    logic [2:0]              nst_reg, nst_next;
    logic [SLOT_W-1:0]       prev_reg, prev_next;
    res_t                    status_reg, status_next;
    logic [SLOT_W-1:0]       it_reg, it_next;
    logic [STEP_W-1:0]       steps_reg, steps_next;
    task_state_t             start_state_reg, start_state_next;
    logic                    hk_seen_reg, hk_seen_next;
    logic                    idle_seen_reg, idle_seen_next;
    logic                    found_reg, found_next;
    logic [SLOT_W-1:0]       nx_reg, nx_next;
    logic                    hold_user_reg, hold_user_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    out_switched_reg, out_switched_next;
    logic [SLOT_W-1:0]       out_prev_reg, out_prev_next;
    logic [SLOT_W-1:0]       out_running_reg, out_running_next;
    res_t                    out_status_reg, out_status_next;

    // Pick logic.
    logic [SLOT_W-1:0]       sel_pick;
    logic                    sel_clr_yield;
    logic                    sel_switch;

    // Synchronous memories with a registered read.
    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            state_mem[st_waddr] <= st_wdata;
        end
        if (ln_we)
        begin
            link_mem[ln_waddr] <= ln_wdata;
        end
        st_rdata_reg   <= state_mem[rd_addr];
        ln_rdata_reg   <= link_mem[rd_addr];
        st_seen_rd_reg <= st_seen_reg[rd_addr];
        ln_seen_rd_reg <= ln_seen_reg[rd_addr];
        rd_addr_reg    <= rd_addr;
    end

    // An entry never written reads as its reset value.
    always_comb
    begin
        rd_state = st_seen_rd_reg ? st_rdata_reg
                 : ((rd_addr_reg == HK_SLOT) ? TS_RUNNING : TS_READY);
        rd_ent.user = ln_seen_rd_reg ? ln_rdata_reg.user : 1'b0;
        rd_ent.link = ln_seen_rd_reg ? ln_rdata_reg.link
                    : ((rd_addr_reg == HK_SLOT) ? IDLE_SLOT : HK_SLOT);
    end

    // Choose the next task once the ring walk is over.
    always_comb
    begin
        sel_pick      = current_reg;
        sel_clr_yield = 1'b0;
        priority if (found_reg)
        begin
            sel_pick      = nx_reg;
            sel_clr_yield = 1'b1;
        end
        else if (hk_seen_reg && (yield_cnt_reg >= hk_interval_reg))
        begin
            sel_pick      = HK_SLOT;
            sel_clr_yield = 1'b1;
        end
        else if ((current_reg != HK_SLOT) && (current_reg != IDLE_SLOT)
                 && runnable(start_state_reg))
        begin
            sel_pick = current_reg;
        end
        else if (hk_seen_reg)
        begin
            sel_pick = HK_SLOT;
        end
        else if (idle_seen_reg)
        begin
            sel_pick = IDLE_SLOT;
        end
        else
        begin
            sel_pick = current_reg;
        end
        // A preemption check never drops a busy task for the idle task.
        sel_switch = (sel_pick != current_reg)
                   && ((op_reg == OP_YIELD) || (sel_pick != IDLE_SLOT)
                       || (current_reg == IDLE_SLOT));
    end

    // Sequencer.
    always_comb
    begin
        fsm_next          = fsm_reg;
        current_next      = current_reg;
        slice_cnt_next    = slice_cnt_reg;
        yield_cnt_next    = yield_cnt_reg;
        slice_ticks_next  = slice_ticks_reg;
        hk_interval_next  = hk_interval_reg;
        valid_next        = valid_reg;
        op_next           = op_reg;
        slot_next         = slot_reg;
        user_next         = user_reg;
        nst_next          = nst_reg;
        prev_next         = prev_reg;
        status_next       = status_reg;
        it_next           = it_reg;
        steps_next        = steps_reg;
        start_state_next  = start_state_reg;
        hk_seen_next      = hk_seen_reg;
        idle_seen_next    = idle_seen_reg;
        found_next        = found_reg;
        nx_next           = nx_reg;
        hold_user_next    = hold_user_reg;
        out_valid_next    = out_valid_reg && out_stall;
        out_switched_next = out_switched_reg;
        out_prev_next     = out_prev_reg;
        out_running_next  = out_running_reg;
        out_status_next   = out_status_reg;
        rd_addr           = current_reg;
        st_we             = 1'b0;
        st_waddr          = current_reg;
        st_wdata          = TS_READY;
        ln_we             = 1'b0;
        ln_waddr          = current_reg;
        ln_wdata.user     = hold_user_reg;
        ln_wdata.link     = slot_reg;

        // Configuration writes.
        if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SLICE_TICKS: slice_ticks_next = cfg_data;
                CFG_HK_INTERVAL: hk_interval_next = cfg_data;
            endcase
        end

        unique case (fsm_reg)
            S_IDLE:
            begin
                // The current slot is read every idle cycle for the next word.
                if (in_valid)
                begin
                    op_next    = op_t'(opcode);
                    slot_next  = task_slot;
                    user_next  = user_task;
                    nst_next   = new_state;
                    prev_next  = current_reg;
                    it_next    = current_reg;
                    steps_next = '0;
                    fsm_next   = S_RESULT;
                    unique case (op_t'(opcode))
                        OP_TICK:
                        begin
                            if (slice_cnt_reg != COUNT_MAX)
                            begin
                                slice_cnt_next = slice_cnt_reg + 8'd1;
                            end
                            status_next = RES_DONE;
                        end
                        OP_YIELD:
                        begin
                            slice_cnt_next = '0;
                            if (yield_cnt_reg != COUNT_MAX)
                            begin
                                yield_cnt_next = yield_cnt_reg + 8'd1;
                            end
                            fsm_next = S_SEL_START;
                        end
                        OP_PREEMPT:
                        begin
                            if (slice_cnt_reg < slice_ticks_reg)
                            begin
                                status_next = RES_NOCHG;
                            end
                            else
                            begin
                                slice_cnt_next = '0;
                                fsm_next       = S_SEL_START;
                            end
                        end
                        OP_ADD:
                        begin
                            if (valid_reg[task_slot])
                            begin
                                status_next = RES_REFUSED;
                            end
                            else
                            begin
                                fsm_next = S_ADD_CUR;
                            end
                        end
                        OP_SET:
                        begin
                            if (!valid_reg[task_slot] || (new_state > TS_STOPPED))
                            begin
                                status_next = RES_REFUSED;
                            end
                            else
                            begin
                                fsm_next = S_SET_WR;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (!valid_reg[task_slot] || (task_slot == current_reg)
                                || (task_slot == HK_SLOT) || (task_slot == IDLE_SLOT))
                            begin
                                status_next = RES_REFUSED;
                            end
                            else
                            begin
                                fsm_next = S_RM_WALK;
                            end
                        end
                        default:
                        begin
                            status_next = RES_NOCHG;
                        end
                    endcase
                end
            end

            S_SEL_START:
            begin
                // The current slot's entry is here; start the walk at its link.
                start_state_next = rd_state;
                hk_seen_next     = (current_reg == HK_SLOT) && runnable(rd_state);
                idle_seen_next   = 1'b0;
                found_next       = 1'b0;
                it_next          = rd_ent.link;
                steps_next       = '0;
                rd_addr          = rd_ent.link;
                fsm_next         = S_SEL_WALK;
            end

            S_SEL_WALK:
            begin
                // One ring link per cycle; the entry of it_reg is here.
                if ((it_reg == current_reg) || (steps_reg == STEP_W'(MAX_TASKS)))
                begin
                    fsm_next = S_DECIDE;
                end
                else if (runnable(rd_state) && (it_reg != HK_SLOT)
                         && (it_reg != IDLE_SLOT))
                begin
                    found_next = 1'b1;
                    nx_next    = it_reg;
                    fsm_next   = S_DECIDE;
                end
                else
                begin
                    if (runnable(rd_state) && (it_reg == IDLE_SLOT))
                    begin
                        idle_seen_next = 1'b1;
                    end
                    if (runnable(rd_state) && (it_reg == HK_SLOT))
                    begin
                        hk_seen_next = 1'b1;
                    end
                    it_next    = rd_ent.link;
                    steps_next = steps_reg + STEP_W'(1);
                    rd_addr    = rd_ent.link;
                end
            end

            S_DECIDE:
            begin
                if (sel_clr_yield)
                begin
                    yield_cnt_next = '0;
                end
                if (sel_switch)
                begin
                    nx_next  = sel_pick;
                    fsm_next = S_SW_PREV;
                end
                else
                begin
                    status_next = RES_NOCHG;
                    fsm_next    = S_RESULT;
                end
            end

            S_SW_PREV:
            begin
                // The outgoing task goes back to ready unless it is a zombie.
                st_we    = (start_state_reg != TS_ZOMBIE);
                st_waddr = current_reg;
                st_wdata = TS_READY;
                fsm_next = S_SW_NEXT;
            end

            S_SW_NEXT:
            begin
                st_we        = 1'b1;
                st_waddr     = nx_reg;
                st_wdata     = TS_RUNNING;
                current_next = nx_reg;
                status_next  = RES_DONE;
                fsm_next     = S_RESULT;
            end

            S_ADD_CUR:
            begin
                // New slot takes over the current slot's successor.
                ln_we                = 1'b1;
                ln_waddr             = slot_reg;
                ln_wdata.user        = user_reg;
                ln_wdata.link        = rd_ent.link;
                st_we                = 1'b1;
                st_waddr             = slot_reg;
                st_wdata             = TS_READY;
                valid_next[slot_reg] = 1'b1;
                hold_user_next       = rd_ent.user;
                fsm_next             = S_ADD_LINK;
            end

            S_ADD_LINK:
            begin
                ln_we         = 1'b1;
                ln_waddr      = current_reg;
                ln_wdata.user = hold_user_reg;
                ln_wdata.link = slot_reg;
                status_next   = RES_DONE;
                fsm_next      = S_RESULT;
            end

            S_SET_WR:
            begin
                st_we       = 1'b1;
                st_waddr    = slot_reg;
                st_wdata    = task_state_t'(nst_reg);
                status_next = RES_DONE;
                fsm_next    = S_RESULT;
            end

            S_RM_WALK:
            begin
                // Search for the predecessor of the slot being removed.
                if (rd_ent.link == slot_reg)
                begin
                    hold_user_next = rd_ent.user;
                    rd_addr        = slot_reg;
                    fsm_next       = S_RM_SLOT;
                end
                else if ((rd_ent.link == current_reg)
                         || (steps_reg == STEP_W'(MAX_TASKS)))
                begin
                    valid_next[slot_reg] = 1'b0;
                    status_next          = RES_DONE;
                    fsm_next             = S_RESULT;
                end
                else
                begin
                    it_next    = rd_ent.link;
                    steps_next = steps_reg + STEP_W'(1);
                    rd_addr    = rd_ent.link;
                end
            end

            S_RM_SLOT:
            begin
                // Predecessor skips over the removed slot.
                ln_we          = 1'b1;
                ln_waddr       = it_reg;
                ln_wdata.user  = hold_user_reg;
                ln_wdata.link  = rd_ent.link;
                hold_user_next = rd_ent.user;
                fsm_next       = S_RM_CLR;
            end

            S_RM_CLR:
            begin
                ln_we                = 1'b1;
                ln_waddr             = slot_reg;
                ln_wdata.user        = hold_user_reg;
                ln_wdata.link        = HK_SLOT;
                valid_next[slot_reg] = 1'b0;
                status_next          = RES_DONE;
                fsm_next             = S_RESULT;
            end

            S_RESULT:
            begin
                // Hand the word over once the output register is free.
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    out_switched_next = (current_reg != prev_reg);
                    out_prev_next     = prev_reg;
                    out_running_next  = current_reg;
                    out_status_next   = status_reg;
                    fsm_next          = S_IDLE;
                end
            end

            default:
            begin
                fsm_next = S_IDLE;
            end
        endcase
    end

    // Control and working registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg          <= S_IDLE;
            current_reg      <= HK_SLOT;
            slice_cnt_reg    <= '0;
            yield_cnt_reg    <= '0;
            slice_ticks_reg  <= SLICE_TICKS_RST;
            hk_interval_reg  <= HK_INTERVAL_RST;
            valid_reg        <= MAX_TASKS'(3);
            st_seen_reg      <= '0;
            ln_seen_reg      <= '0;
            out_valid_reg    <= 1'b0;
            op_reg           <= OP_TICK;
            slot_reg         <= '0;
            user_reg         <= 1'b0;
            nst_reg          <= '0;
            prev_reg         <= '0;
            status_reg       <= RES_NOCHG;
            it_reg           <= '0;
            steps_reg        <= '0;
            start_state_reg  <= TS_READY;
            hk_seen_reg      <= 1'b0;
            idle_seen_reg    <= 1'b0;
            found_reg        <= 1'b0;
            nx_reg           <= '0;
            hold_user_reg    <= 1'b0;
            out_switched_reg <= 1'b0;
            out_prev_reg     <= '0;
            out_running_reg  <= '0;
            out_status_reg   <= RES_NOCHG;
        end
        else
        begin
            fsm_reg          <= fsm_next;
            current_reg      <= current_next;
            slice_cnt_reg    <= slice_cnt_next;
            yield_cnt_reg    <= yield_cnt_next;
            slice_ticks_reg  <= slice_ticks_next;
            hk_interval_reg  <= hk_interval_next;
            valid_reg        <= valid_next;
            if (st_we)
            begin
                st_seen_reg[st_waddr] <= 1'b1;
            end
            if (ln_we)
            begin
                ln_seen_reg[ln_waddr] <= 1'b1;
            end
            out_valid_reg    <= out_valid_next;
            op_reg           <= op_next;
            slot_reg         <= slot_next;
            user_reg         <= user_next;
            nst_reg          <= nst_next;
            prev_reg         <= prev_next;
            status_reg       <= status_next;
            it_reg           <= it_next;
            steps_reg        <= steps_next;
            start_state_reg  <= start_state_next;
            hk_seen_reg      <= hk_seen_next;
            idle_seen_reg    <= idle_seen_next;
            found_reg        <= found_next;
            nx_reg           <= nx_next;
            hold_user_reg    <= hold_user_next;
            out_switched_reg <= out_switched_next;
            out_prev_reg     <= out_prev_next;
            out_running_reg  <= out_running_next;
            out_status_reg   <= out_status_next;
        end
    end

    // Ports.
    assign in_stall     = (fsm_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign switched     = out_switched_reg;
    assign prev_task    = out_prev_reg;
    assign running_task = out_running_reg;
    assign status       = out_status_reg;

    // Checks.
    `include "ring_task_picker_assert.svh"

    `RTP_ASSERT_ALWAYS(a_fixed_slots_valid, clk, rst_n, valid_reg[HK_SLOT] && valid_reg[IDLE_SLOT])
    `RTP_ASSERT_ALWAYS(a_current_valid, clk, rst_n, valid_reg[current_reg])
    `RTP_ASSERT_IMPLY(a_no_write_in_walk, clk, rst_n, (fsm_reg == S_SEL_WALK) || (fsm_reg == S_RM_WALK), !st_we && !ln_we)
    `RTP_ASSERT_NEXT(a_switch_moves_current, clk, rst_n, fsm_reg == S_SW_NEXT, (fsm_reg == S_RESULT) && (current_reg != prev_reg))
    `RTP_ASSERT_IMPLY(a_switch_is_done, clk, rst_n, out_valid && switched, status == RES_DONE)

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    import rtp_pkg::*;

    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;

    // One result word as the checker sees it.
    typedef struct packed
    {
        logic              sw;
        logic [SLOT_W-1:0] from_slot;
        logic [SLOT_W-1:0] to_slot;
        res_t              code;
    } pick_result_t;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_stall;
    logic [2:0]          opcode     = 3'd0;
    logic [SLOT_W-1:0]   task_slot  = '0;
    logic                user_task  = 1'b0;
    logic [2:0]          new_state  = 3'd0;
    logic                out_valid;
    logic                out_stall  = 1'b0;
    logic                switched;
    logic [SLOT_W-1:0]   prev_task;
    logic [SLOT_W-1:0]   running_task;
    logic [1:0]          status;
    logic                cfg_valid  = 1'b0;
    logic                cfg_ready;
    cfg_idx_t            cfg_index  = CFG_SLICE_TICKS;
    logic [7:0]          cfg_data   = 8'd0;

    // Scheduler mirror kept by the testbench.
    task_state_t         slot_st    [MAX_TASKS];
    logic                slot_usr   [MAX_TASKS];
    logic                slot_inuse [MAX_TASKS];
    logic [SLOT_W-1:0]   ring_link  [MAX_TASKS];
    logic [SLOT_W-1:0]   sched_cur;
    logic [7:0]          slice_cnt;
    logic [7:0]          yield_cnt;
    logic [7:0]          m_slice_ticks;
    logic [7:0]          m_hk_interval;

    pick_result_t        expected_picks [$];
    pick_result_t        want_pick;
    int                  mismatches     = 0;
    int                  send_idle_pct  = 14;
    int                  recv_stall_pct = 88;
    int                  hold_seq       = 0;
    int                  hold_seen      = 0;
    int                  hold_left      = 0;
    int                  idle_run;

    ring_task_picker DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .task_slot    (task_slot),
        .user_task    (user_task),
        .new_state    (new_state),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .switched     (switched),
        .prev_task    (prev_task),
        .running_task (running_task),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Free-running clock, 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mirror state after reset.
    function automatic void sched_reset();
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            slot_st[i]    = TS_READY;
            slot_usr[i]   = 1'b0;
            slot_inuse[i] = 1'b0;
            ring_link[i]  = '0;
        end
        slot_st[HK_SLOT]      = TS_RUNNING;
        slot_inuse[HK_SLOT]   = 1'b1;
        slot_inuse[IDLE_SLOT] = 1'b1;
        ring_link[HK_SLOT]    = IDLE_SLOT;
        ring_link[IDLE_SLOT]  = HK_SLOT;
        sched_cur     = HK_SLOT;
        slice_cnt     = 8'd0;
        yield_cnt     = 8'd0;
        m_slice_ticks = SLICE_TICKS_RST;
        m_hk_interval = HK_INTERVAL_RST;
    endfunction

    function automatic logic can_run(input logic [SLOT_W-1:0] s);
        return (slot_st[s] == TS_READY) || (slot_st[s] == TS_RUNNING);
    endfunction

    // Walk the ring from the current task and choose who runs next.
    function automatic logic [SLOT_W-1:0] choose_runner();
        logic [SLOT_W-1:0] start;
        logic [SLOT_W-1:0] it;
        logic              hk;
        logic              idl;
        int                steps;
        start = sched_cur;
        hk    = (start == HK_SLOT) && can_run(start);
        idl   = 1'b0;
        it    = ring_link[start];
        steps = 0;
        while (it != start && steps < MAX_TASKS)
        begin
            if (can_run(it))
            begin
                if (it != HK_SLOT && it != IDLE_SLOT)
                begin
                    yield_cnt = 8'd0;
                    return it;
                end
                if (it == IDLE_SLOT)
                    idl = 1'b1;
                else
                    hk = 1'b1;
            end
            it = ring_link[it];
            steps++;
        end
        if (hk && yield_cnt >= m_hk_interval)
        begin
            yield_cnt = 8'd0;
            return HK_SLOT;
        end
        if (start != HK_SLOT && start != IDLE_SLOT && can_run(start))
            return start;
        if (hk)
            return HK_SLOT;
        if (idl)
            return IDLE_SLOT;
        return start;
    endfunction

    // The outgoing task goes back to ready unless it is a zombie.
    function automatic void switch_to(input logic [SLOT_W-1:0] nx);
        if (slot_st[sched_cur] != TS_ZOMBIE)
            slot_st[sched_cur] = TS_READY;
        slot_st[nx] = TS_RUNNING;
        sched_cur   = nx;
    endfunction

    // Apply one operation word to the mirror and return the result it gives.
    function automatic pick_result_t predict_pick(input logic [2:0] op,
                                                  input logic [SLOT_W-1:0] slot,
                                                  input logic user,
                                                  input logic [2:0] nst);
        pick_result_t      r;
        logic [SLOT_W-1:0] prev;
        logic [SLOT_W-1:0] nx;
        logic [SLOT_W-1:0] p;
        int                steps;
        prev   = sched_cur;
        r.code = RES_NOCHG;
        case (op)
            OP_TICK:
            begin
                if (slice_cnt != COUNT_MAX)
                    slice_cnt++;
                r.code = RES_DONE;
            end
            OP_YIELD:
            begin
                slice_cnt = 8'd0;
                if (yield_cnt != COUNT_MAX)
                    yield_cnt++;
                nx = choose_runner();
                if (nx != prev)
                begin
                    switch_to(nx);
                    r.code = RES_DONE;
                end
            end
            OP_PREEMPT:
            begin
                if (slice_cnt >= m_slice_ticks)
                begin
                    slice_cnt = 8'd0;
                    nx = choose_runner();
                    if (!(nx == prev || (nx == IDLE_SLOT && prev != IDLE_SLOT)))
                    begin
                        switch_to(nx);
                        r.code = RES_DONE;
                    end
                end
            end
            OP_ADD:
            begin
                if (slot_inuse[slot])
                    r.code = RES_REFUSED;
                else
                begin
                    ring_link[slot]      = ring_link[sched_cur];
                    ring_link[sched_cur] = slot;
                    slot_st[slot]        = TS_READY;
                    slot_usr[slot]       = user;
                    slot_inuse[slot]     = 1'b1;
                    r.code               = RES_DONE;
                end
            end
            OP_SET:
            begin
                if (!slot_inuse[slot] || nst > TS_STOPPED)
                    r.code = RES_REFUSED;
                else
                begin
                    slot_st[slot] = task_state_t'(nst);
                    r.code        = RES_DONE;
                end
            end
            OP_REMOVE:
            begin
                if (!slot_inuse[slot] || slot == sched_cur || slot == HK_SLOT
                    || slot == IDLE_SLOT)
                    r.code = RES_REFUSED;
                else
                begin
                    // Find the predecessor, at most one full lap.
                    p     = sched_cur;
                    steps = 0;
                    while (ring_link[p] != slot && ring_link[p] != sched_cur
                           && steps < MAX_TASKS)
                    begin
                        p = ring_link[p];
                        steps++;
                    end
                    if (ring_link[p] == slot)
                    begin
                        ring_link[p]    = ring_link[slot];
                        ring_link[slot] = '0;
                    end
                    slot_inuse[slot] = 1'b0;
                    r.code           = RES_DONE;
                end
            end
            default:
            begin
            end
        endcase
        r.sw        = (sched_cur != prev);
        r.from_slot = prev;
        r.to_slot   = sched_cur;
        return r;
    endfunction

    task automatic report_field(input string name, input logic [7:0] exp_v,
                                input logic [7:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // Check each result word against the oldest expectation, then predict
    // for each operation word taken at this edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_picks.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, actual %0d %0d %0d %0d",
                         $time, switched, prev_task, running_task, status);
                mismatches++;
            end
            else
            begin
                want_pick = expected_picks.pop_front();
                report_field("switched", 8'(want_pick.sw), 8'(switched));
                report_field("prev_task", 8'(want_pick.from_slot), 8'(prev_task));
                report_field("running_task", 8'(want_pick.to_slot), 8'(running_task));
                report_field("status", 8'(want_pick.code), 8'(status));
            end
        end
        if (rst_n && in_valid && !in_stall)
            expected_picks.push_back(predict_pick(opcode, task_slot, user_task, new_state));
    end

    // Result side: random stall, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Give up when nothing at all moves for too long.
    initial
    begin
        idle_run = 0;
        while (idle_run < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("FAIL ring_task_picker");
        $finish;
    end

    // Offer one operation word, with a random gap ahead of it.
    task automatic send_word(input logic [2:0] op, input logic [SLOT_W-1:0] slot,
                             input logic user, input logic [2:0] nst);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        task_slot <= slot;
        user_task <= user;
        new_state <= nst;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
    endtask

    // A random word, weighted toward ticks and preemption checks.
    task automatic send_random_word();
        int                r;
        logic [2:0]        op;
        logic [SLOT_W-1:0] slot;
        logic [2:0]        nst;
        r = $urandom_range(99);
        if (r < 25)
            op = OP_TICK;
        else if (r < 40)
            op = OP_YIELD;
        else if (r < 60)
            op = OP_PREEMPT;
        else if (r < 73)
            op = OP_ADD;
        else if (r < 86)
            op = OP_SET;
        else if (r < 97)
            op = OP_REMOVE;
        else
            op = 3'($urandom_range(7, 6));
        slot = ($urandom_range(9) == 0) ? SLOT_W'($urandom_range(1))
                                        : SLOT_W'($urandom_range(15, 2));
        nst  = ($urandom_range(6) == 0) ? 3'($urandom_range(7, 5))
                                        : 3'($urandom_range(4));
        send_word(op, slot, 1'($urandom_range(1)), nst);
    endtask

    // Stop sending and let every outstanding result drain.
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_picks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both registers back to back; valid stays up between them.
    task automatic set_config(input logic [7:0] slice_v, input logic [7:0] hk_v);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_SLICE_TICKS;
        cfg_data  <= slice_v;
        do
            @(posedge clk);
        while (!cfg_ready);
        m_slice_ticks = slice_v;
        cfg_index <= CFG_HK_INTERVAL;
        cfg_data  <= hk_v;
        do
            @(posedge clk);
        while (!cfg_ready);
        m_hk_interval = hk_v;
        cfg_valid <= 1'b0;
    endtask

    // Fixed slots, refusals, bad states, unused opcodes and a zombie switch.
    task automatic test_directed();
        set_config(8'd1, 8'd1);
        send_word(OP_TICK, 4'd0, 1'b0, 3'd0);
        send_word(OP_PREEMPT, 4'd0, 1'b0, 3'd0);
        send_word(OP_YIELD, 4'd0, 1'b0, 3'd0);
        send_word(OP_ADD, 4'd2, 1'b1, 3'd0);
        send_word(OP_ADD, 4'd15, 1'b0, 3'd7);
        send_word(OP_ADD, HK_SLOT, 1'b0, 3'd0);
        send_word(OP_ADD, IDLE_SLOT, 1'b1, 3'd0);
        send_word(OP_ADD, 4'd2, 1'b0, 3'd0);
        send_word(OP_YIELD, 4'd0, 1'b0, 3'd0);
        send_word(OP_TICK, 4'd0, 1'b0, 3'd0);
        send_word(OP_PREEMPT, 4'd0, 1'b0, 3'd0);
        send_word(OP_SET, 4'd15, 1'b0, TS_BLOCKED);
        send_word(OP_SET, 4'd7, 1'b0, TS_READY);
        send_word(OP_SET, 4'd2, 1'b0, 3'd5);
        send_word(OP_SET, 4'd2, 1'b1, 3'd7);
        send_word(OP_REMOVE, 4'd2, 1'b0, 3'd0);
        send_word(OP_REMOVE, HK_SLOT, 1'b0, 3'd0);
        send_word(OP_REMOVE, IDLE_SLOT, 1'b0, 3'd0);
        send_word(OP_REMOVE, 4'd9, 1'b0, 3'd0);
        send_word(OP_SET, 4'd2, 1'b0, TS_ZOMBIE);
        send_word(OP_YIELD, 4'd0, 1'b0, 3'd0);
        send_word(OP_REMOVE, 4'd2, 1'b0, 3'd0);
        send_word(OP_REMOVE, 4'd15, 1'b0, 3'd0);
        send_word(3'd6, 4'd15, 1'b1, 3'd7);
        send_word(3'd7, 4'd0, 1'b0, 3'd0);
        settle();
    endtask

    // The yield count saturates while the housekeeping task is held off.
    task automatic test_saturation();
        set_config(8'd255, 8'd255);
        send_word(OP_SET, HK_SLOT, 1'b0, TS_BLOCKED);
        send_word(OP_YIELD, 4'd0, 1'b0, 3'd0);
        send_word(OP_SET, HK_SLOT, 1'b0, TS_BLOCKED);
        repeat (256) send_word(OP_YIELD, 4'd0, 1'b0, 3'd0);
        send_word(OP_SET, HK_SLOT, 1'b0, TS_READY);
        send_word(OP_YIELD, 4'd0, 1'b0, 3'd0);
        settle();
    endtask

    // Random words under one idling mix and one register setting.
    task automatic test_random(input int idle_s, input int idle_r,
                               input logic [7:0] slice_v, input logic [7:0] hk_v,
                               input int count);
        settle();
        set_config(slice_v, hk_v);
        send_idle_pct  = idle_s;
        recv_stall_pct = idle_r;
        repeat (count) send_random_word();
    endtask

    // Hold the result side off so the block backs up, then drain fully.
    task automatic test_backpressure();
        hold_seq = hold_seq + 1;
        repeat (24) send_random_word();
        settle();
    endtask

    initial
    begin
        sched_reset();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_saturation();
        test_random(14, 88, 8'd3, 8'd2, 35);
        test_backpressure();
        test_random(88, 14, 8'($urandom_range(20, 1)), 8'($urandom_range(20, 1)), 35);
        test_random(0, 0, SLICE_TICKS_RST, HK_INTERVAL_RST, 35);
        settle();

        if (mismatches == 0 && expected_picks.size() == 0)
            $display("PASS ring_task_picker");
        else
            $display("FAIL ring_task_picker");
        $finish;
    end

endmodule
